### sv/bitmap_store_find_first_set_unit_defines.svh
// assertion macros for the bit map store
// used by the top level; needs nothing else
`ifndef BITMAP_STORE_FIND_FIRST_SET_UNIT_DEFINES_SVH
`define BITMAP_STORE_FIND_FIRST_SET_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BSF_ASSERT_NOW(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("bit map store check failed");

// next-cycle implication, off while reset is high
`define BSF_ASSERT_NEXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("bit map store check failed");

`endif

### sv/bsf_pkg.sv
// shared types, operation codes and defaults for the bit map store
// no dependencies
`default_nettype none

package bsf_pkg;

  localparam int MAX_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 64;
  localparam int SUM_CHUNK     = 8;

  localparam logic [12:0] NUM_ELEMENTS_RST = 13'd4096;

  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [63:0] FILL_WORD64 = {8{FILL_BYTE}};

  localparam logic [2:0] OP_GET       = 3'd0;
  localparam logic [2:0] OP_SET       = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_SET_ALL   = 3'd4;
  localparam logic [2:0] OP_FIND      = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] bit_index;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        bit_value;
    logic        found;
    logic [11:0] first_position;
  } out_item_t;

endpackage

`default_nettype wire

### sv/bitmap_store_find_first_set_unit.sv
// bit map store with find-first-set; needs bsf_pkg and the assertion macro header
// steps, accept to result register: out-of-range, clear all, set all and unused codes
// load the result at accept; get, set and clear do one word read, then set and clear write back
// find first scans the 8-word chunks of the nonempty summary in turn, then reads the
// word when a nonempty word turns up; one request in flight, next accept with result
// synchronous reset: store reads as all zeros at once via per-word written flags, limit 4096
`default_nettype none

`include "bitmap_store_find_first_set_unit_defines.svh"

module bitmap_store_find_first_set_unit #(
  parameter int MAX_BITS  = bsf_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bsf_pkg::WORD_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [12:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bsf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bsf_pkg::out_item_t  out_data
);

  localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int PW     = ($clog2(MAX_BITS) + 1 > 13) ? $clog2(MAX_BITS) + 1 : 13;
  localparam int CHUNK  = bsf_pkg::SUM_CHUNK;
  localparam int CHW    = $clog2(CHUNK);
  localparam int NCHUNK = (NWORDS + CHUNK - 1) / CHUNK;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int RSH    = 24;
  localparam logic [24:0] RECIP = 25'((2**RSH + WORD_BITS - 1) / WORD_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FRD  = 2'd3;

  localparam logic [WORD_BITS-1:0] FILL_WORD = bsf_pkg::FILL_WORD64[WORD_BITS-1:0];

  logic [1:0]            state;
  logic [2:0]            op;
  logic [11:0]           idx;
  logic [AW-1:0]         widx;
  logic [CW-1:0]         chunk;
  logic                  fill;
  logic [NWORDS-1:0]     written;
  logic [NWORDS-1:0]     nonempty;
  logic [12:0]           num_elements;
  logic [WORD_BITS-1:0]  rdata;
  logic [WORD_BITS-1:0]  mem [NWORDS];

  logic [PW-1:0]                lim;
  logic [36:0]                  prod;
  logic [AW-1:0]                in_widx;
  logic                         in_range;
  logic                         in_acc;
  logic                         in_find;
  logic                         in_bitop;
  logic                         res_load;
  logic [AW-1:0]                rd_addr;
  logic [WORD_BITS-1:0]         cur_word;
  logic [PW-1:0]                off_full;
  logic [BW-1:0]                off;
  logic [WORD_BITS-1:0]         new_word;
  logic                         mem_we;
  logic [NCHUNK*CHUNK-1:0]      sum_pad;
  logic [CHUNK-1:0]             chunk_bits;
  logic [CHW-1:0]               enc;
  logic [AW-1:0]                scan_widx;
  logic                         last_chunk;
  logic [BW-1:0]                low_bit;
  logic [PW-1:0]                pos;

  assign lim = (PW'(num_elements) > PW'(MAX_BITS)) ? PW'(MAX_BITS) : PW'(num_elements);

  // word index by reciprocal multiply, exact for 12-bit indexes
  assign prod     = 37'(in_data.bit_index) * 37'(RECIP);
  assign in_widx  = AW'(prod[36:RSH]);
  assign in_range = PW'(in_data.bit_index) < lim;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign in_find  = in_acc && (in_data.operation == bsf_pkg::OP_FIND);
  assign in_bitop = (in_data.operation == bsf_pkg::OP_GET) ||
                    (in_data.operation == bsf_pkg::OP_SET) ||
                    (in_data.operation == bsf_pkg::OP_CLEAR);

  // words never written since the last fill read as the fill pattern
  assign cur_word = written[widx] ? rdata : (fill ? FILL_WORD : '0);
  assign off_full = PW'(idx) - PW'(widx) * PW'(WORD_BITS);
  assign off      = off_full[BW-1:0];
  assign new_word = (op == bsf_pkg::OP_SET) ? (cur_word | (WORD_BITS'(1) << off))
                                            : (cur_word & ~(WORD_BITS'(1) << off));
  assign mem_we   = (state == ST_RD) && (op != bsf_pkg::OP_GET);

  assign sum_pad    = (NCHUNK*CHUNK)'(nonempty);
  assign chunk_bits = sum_pad[chunk*CHUNK +: CHUNK];
  assign last_chunk = chunk == CW'(NCHUNK - 1);

  // result register loads on this edge
  assign res_load = (in_acc && !(in_bitop && in_range) && !in_find) ||
                    (state == ST_RD) || (state == ST_FRD) ||
                    ((state == ST_SCAN) && !(|chunk_bits) && last_chunk);

  always_comb begin
    enc = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        enc = CHW'(i);
      end
    end
  end

  assign scan_widx = AW'({chunk, enc});

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cur_word[i]) begin
        low_bit = BW'(i);
      end
    end
  end

  assign pos = PW'(widx) * PW'(WORD_BITS) + PW'(low_bit);

  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = in_widx;
      ST_SCAN: rd_addr = scan_widx;
      ST_RD,
      ST_FRD:  rd_addr = widx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[widx] <= new_word;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      fill         <= 1'b0;
      written      <= '0;
      nonempty     <= '0;
      num_elements <= bsf_pkg::NUM_ELEMENTS_RST;
      chunk        <= '0;
    end else begin
      if (cfg_we) begin
        num_elements <= cfg_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op    <= in_data.operation;
            idx   <= in_data.bit_index;
            widx  <= in_widx;
            chunk <= '0;
            if (in_bitop && in_range) begin
              state <= ST_RD;
            end else if (in_data.operation == bsf_pkg::OP_FIND) begin
              state <= ST_SCAN;
            end else begin
              out_data <= {in_bitop, 1'b0, 1'b0, 12'd0};
              if (in_data.operation == bsf_pkg::OP_CLEAR_ALL) begin
                written  <= '0;
                nonempty <= '0;
                fill     <= 1'b0;
              end else if (in_data.operation == bsf_pkg::OP_SET_ALL) begin
                written  <= '0;
                nonempty <= '1;
                fill     <= 1'b1;
              end
            end
          end
        end
        ST_RD: begin
          if (op != bsf_pkg::OP_GET) begin
            written[widx]  <= 1'b1;
            nonempty[widx] <= |new_word;
          end
          out_data <= {1'b0, (op == bsf_pkg::OP_GET) && cur_word[off], 1'b0, 12'd0};
          state    <= ST_IDLE;
        end
        ST_SCAN: begin
          if (|chunk_bits) begin
            widx  <= scan_widx;
            state <= ST_FRD;
          end else if (last_chunk) begin
            out_data <= '0;
            state    <= ST_IDLE;
          end else begin
            chunk <= CW'(chunk + 1'b1);
          end
        end
        ST_FRD: begin
          out_data <= {1'b0, 1'b0, pos < lim, (pos < lim) ? pos[11:0] : 12'd0};
          state    <= ST_IDLE;
        end
      endcase
    end
  end

  `BSF_ASSERT_NEXT(a_find_starts_scan, clk, rst, in_find, state == ST_SCAN)
  `BSF_ASSERT_NOW(a_rd_after_accept, clk, rst, state == ST_RD, $past(in_acc))
  `BSF_ASSERT_NOW(a_frd_after_scan, clk, rst, state == ST_FRD, $past(state) == ST_SCAN)
  `BSF_ASSERT_NOW(a_chunk_only_in_scan, clk, rst, state == ST_SCAN && chunk != '0, $past(state) == ST_SCAN)

endmodule

`default_nettype wire
